### hdl/adc2p_pkg.sv
`timescale 1ns / 1ps

package adc2p_pkg;

	localparam int MAX_CHANNELS      = 16;
	localparam int DEF_CHANNEL_COUNT = 16;
	localparam int DEF_CAL_CODE_LOW  = 2064;
	localparam int DEF_CAL_CODE_HIGH = 3112;

	localparam int SCALE   = 1000;
	localparam int MAX_OUT = 32767;
	localparam int MAX12   = 4095;
	localparam int OFS_MIN = -1048576;
	localparam int OFS_MAX = 1048575;

	localparam int CH_W     = 4;
	localparam int CODE_W   = 12;
	localparam int TRIM_W   = 8;
	localparam int VALUE_W  = 15;
	localparam int STATUS_W = 2;
	localparam int K_W      = 12;
	localparam int OFS_W    = 21;

	localparam int S_TDATA_W = 32;
	localparam int S_TUSER_W = 1;
	localparam int M_TDATA_W = 16;
	localparam int M_TUSER_W = 2;

	localparam int SAT_PROD = (MAX_OUT + 1) * SCALE;
	localparam int DIV_N_W  = $clog2(SAT_PROD + 1);
	localparam int MUL_P_W  = DIV_N_W + K_W;

	localparam logic OP_CALIBRATE = 1'b0;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_INPUT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_UNCAL    = 2'd2;

	localparam int VOLT_LOW [MAX_CHANNELS] = '{
		630, 630, 1260, 630, 630, 630, 2520, 2520,
		3150, 5670, 3465, 0, 0, 0, 3645, 0
	};
	localparam int VOLT_HIGH [MAX_CHANNELS] = '{
		950, 950, 1900, 950, 950, 950, 3800, 3800,
		4750, 8550, 5225, 0, 0, 0, 5225, 0
	};

	// Bit n set marks channel n as a bypass channel.
	localparam logic [MAX_CHANNELS-1:0] BYPASS_INIT = 16'hB800;

endpackage

### hdl/adc2p_mul.sv
`timescale 1ns / 1ps

module adc2p_mul #(
	parameter int A_W = adc2p_pkg::DIV_N_W,
	parameter int B_W = adc2p_pkg::K_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [A_W-1:0]   a,
	input  logic [B_W-1:0]   b,
	output logic [A_W+B_W-1:0] product,
	output logic             done
);

	localparam int P_W   = A_W + B_W;
	localparam int CNT_W = $clog2(B_W + 1);

	logic [P_W-1:0]   acc_q;
	logic [A_W-1:0]   a_q;
	logic [B_W-1:0]   b_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(B_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// One multiplier bit per cycle, most significant first.
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= a;
			b_q   <= b;
		end else if (busy_q) begin
			acc_q <= {acc_q[P_W-2:0], 1'b0} + (b_q[B_W-1] ? P_W'(a_q) : '0);
			b_q   <= {b_q[B_W-2:0], 1'b0};
		end
	end

	assign product = acc_q;
	assign done    = done_q;

endmodule

### hdl/adc2p_div.sv
`timescale 1ns / 1ps

module adc2p_div #(
	parameter int N_W = adc2p_pkg::DIV_N_W,
	parameter int D_W = adc2p_pkg::K_W
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [N_W-1:0] dividend,
	input  logic [D_W-1:0] divisor,
	output logic [N_W-1:0] quotient,
	output logic           done
);

	localparam int CNT_W = $clog2(N_W + 1);

	logic [D_W-1:0]   rem_q;
	logic [D_W-1:0]   divisor_q;
	logic [N_W-1:0]   quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [D_W:0]     shifted;
	logic [D_W+1:0]   trial;
	logic             ge;

	always_comb begin
		shifted = {rem_q, quo_q[N_W-1]};
		trial   = {1'b0, shifted} - {2'b00, divisor_q};
		ge      = !trial[D_W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(N_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Restoring division: dividend bits leave at the top while quotient bits enter below.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q     <= '0;
			quo_q     <= dividend;
			divisor_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? trial[D_W-1:0] : shifted[D_W-1:0];
			quo_q <= {quo_q[N_W-2:0], ge};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

### hdl/adc_two_point_calibration.sv
`timescale 1ns / 1ps

// Channel  Dir  Fields, lowest bit first
// s_*      in   tdata: channel[3:0] raw_code[15:4] trim_low[23:16] trim_high[31:24]
//                tuser: opcode[0]
// m_*      out  tdata: corrected_value[14:0], zero pad [15]; tuser: status[1:0]
//
// One item at a time. A calibrate request runs one 25-step division and one 12-step
// multiplication; a correct request runs two divisions and one multiplication;
// requests that end early skip the divider and the multiplier.
// Reset clears the calibrated flags; nothing else needs a clearing pass.
// The result register lets the next request start while a result waits on m_tready.

module adc_two_point_calibration #(
	parameter int CHANNEL_COUNT = adc2p_pkg::DEF_CHANNEL_COUNT,
	parameter int CAL_CODE_LOW  = adc2p_pkg::DEF_CAL_CODE_LOW,
	parameter int CAL_CODE_HIGH = adc2p_pkg::DEF_CAL_CODE_HIGH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [adc2p_pkg::S_TDATA_W-1:0] s_tdata,  // channel, raw_code, trim_low, trim_high
	input  logic [adc2p_pkg::S_TUSER_W-1:0] s_tuser,  // opcode
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [adc2p_pkg::M_TDATA_W-1:0] m_tdata,  // corrected_value, zero pad
	output logic [adc2p_pkg::M_TUSER_W-1:0] m_tuser   // status
);

	import adc2p_pkg::*;

	localparam int CH_IDX_W  = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
	localparam int CAL_SPAN  = (CAL_CODE_HIGH > CAL_CODE_LOW) ? CAL_CODE_HIGH - CAL_CODE_LOW : 1;
	localparam int TRIM_SC_W = $clog2((2 ** TRIM_W - 1) * SCALE + 1);
	localparam int RAW_SC_W  = $clog2((2 ** CODE_W - 1) * SCALE + 1);
	localparam int DIFF_W    = RAW_SC_W + 2;
	localparam int KW_W      = DIV_N_W + 2;

	localparam logic [CH_W:0]             NCH        = (CH_W + 1)'(CHANNEL_COUNT);
	localparam logic [K_W-1:0]            SPAN_K     = K_W'(CAL_SPAN);
	localparam logic [K_W-1:0]            CAL_LOW_K  = K_W'(CAL_CODE_LOW);
	localparam logic [K_W-1:0]            SCALE_K    = K_W'(SCALE);
	localparam logic signed [KW_W-1:0]    OFS_LO     = KW_W'(OFS_MIN);
	localparam logic signed [KW_W-1:0]    OFS_HI     = KW_W'(OFS_MAX);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_DECODE = 5'b00010,
		S_DIV    = 5'b00100,
		S_MUL    = 5'b01000,
		S_DONE   = 5'b10000
	} state_t;

	state_t state_q, state_d;

	logic                opcode_q;
	logic [CH_W-1:0]     channel_q;
	logic [CODE_W-1:0]   raw_q;
	logic [TRIM_W-1:0]   trim_low_q;
	logic [TRIM_W-1:0]   trim_high_q;
	logic                scale_q;
	logic [K_W-1:0]      k_q;
	logic                dneg_q;
	logic [VALUE_W-1:0]  res_value_q;
	logic [STATUS_W-1:0] res_status_q;
	logic                out_valid_q;
	logic [VALUE_W-1:0]  out_value_q;
	logic [STATUS_W-1:0] out_status_q;

	logic [K_W-1:0]           gain_err_q [CHANNEL_COUNT];
	logic [OFS_W-1:0]         ofs_store_q [CHANNEL_COUNT];
	logic [CHANNEL_COUNT-1:0] cal_flags_q;
	logic [K_W-1:0]           gain_rom [CHANNEL_COUNT];
	logic [CHANNEL_COUNT-1:0] bypass_rom;

	genvar g;
	generate
		for (g = 0; g < CHANNEL_COUNT; g++) begin : g_rom
			localparam int GainRaw = ((VOLT_HIGH[g] - VOLT_LOW[g]) * SCALE) / CAL_SPAN;
			localparam int GainSat = (GainRaw < 0) ? 0 : ((GainRaw > MAX12) ? MAX12 : GainRaw);
			assign gain_rom[g]   = K_W'(GainSat);
			assign bypass_rom[g] = BYPASS_INIT[g];
		end
	endgenerate

	logic                 in_accept;
	logic [CH_IDX_W-1:0]  ch_idx;
	logic                 ch_ok;
	logic                 byp_rd;
	logic                 cal_rd;
	logic [K_W-1:0]       kdiv_rd;
	logic [TRIM_W:0]      trim_diff;
	logic                 cal_neg;
	logic [TRIM_W-1:0]    trim_mag;
	logic [TRIM_SC_W-1:0] trim_sc;
	logic [TRIM_SC_W-1:0] low_sc;
	logic [RAW_SC_W-1:0]  raw_sc;
	logic [DIFF_W-1:0]    diff;
	logic [KW_W-1:0]      k_wide;
	logic [K_W-1:0]       k_cl;
	logic [K_W:0]         delta;
	logic                 dneg;
	logic [K_W-1:0]       dmag;
	logic signed [KW_W-1:0] ofs_wide;
	logic [OFS_W-1:0]     ofs_cl;
	logic [DIV_N_W-1:0]   prod_sat;
	logic [VALUE_W-1:0]   val_cl;

	logic               div_start, div_done;
	logic [DIV_N_W-1:0] div_n, div_q;
	logic [K_W-1:0]     div_d;
	logic               mul_start, mul_done;
	logic [DIV_N_W-1:0] mul_a;
	logic [K_W-1:0]     mul_b;
	logic [MUL_P_W-1:0] mul_p;

	logic                k_load, scale_set, store_we, res_load, out_load;
	logic [VALUE_W-1:0]  res_value_d;
	logic [STATUS_W-1:0] res_status_d;

	assign s_tready  = (state_q == S_IDLE);
	assign in_accept = s_tvalid && s_tready;

	always_comb begin
		ch_idx    = channel_q[CH_IDX_W-1:0];
		ch_ok     = ({1'b0, channel_q} < NCH);
		byp_rd    = bypass_rom[ch_idx];
		cal_rd    = cal_flags_q[ch_idx];
		kdiv_rd   = (gain_err_q[ch_idx] == '0) ? K_W'(1) : gain_err_q[ch_idx];

		trim_diff = {1'b0, trim_high_q} - {1'b0, trim_low_q};
		cal_neg   = trim_diff[TRIM_W];
		trim_mag  = cal_neg ? TRIM_W'(-trim_diff) : trim_diff[TRIM_W-1:0];
		trim_sc   = TRIM_SC_W'(trim_mag * SCALE);
		low_sc    = TRIM_SC_W'(trim_low_q * SCALE);
		raw_sc    = RAW_SC_W'(raw_q * SCALE);
		diff      = DIFF_W'(raw_sc) - DIFF_W'($signed(ofs_store_q[ch_idx]));

		k_wide = cal_neg ? (KW_W'(SCALE) - KW_W'(div_q)) : (KW_W'(SCALE) + KW_W'(div_q));
		if (k_wide[KW_W-1] || (k_wide == '0)) begin
			k_cl = K_W'(1);
		end else if (k_wide > KW_W'(MAX12)) begin
			k_cl = K_W'(MAX12);
		end else begin
			k_cl = k_wide[K_W-1:0];
		end
		delta = {1'b0, k_cl} - (K_W + 1)'(SCALE);
		dneg  = delta[K_W];
		dmag  = dneg ? K_W'(-delta) : delta[K_W-1:0];

		ofs_wide = dneg_q ? $signed(KW_W'(low_sc) + KW_W'(mul_p[DIV_N_W-1:0]))
		                  : $signed(KW_W'(low_sc) - KW_W'(mul_p[DIV_N_W-1:0]));
		if (ofs_wide < OFS_LO) begin
			ofs_cl = OFS_W'(OFS_LO);
		end else if (ofs_wide > OFS_HI) begin
			ofs_cl = OFS_W'(OFS_HI);
		end else begin
			ofs_cl = ofs_wide[OFS_W-1:0];
		end

		prod_sat = (mul_p >= MUL_P_W'(SAT_PROD)) ? DIV_N_W'(SAT_PROD) : mul_p[DIV_N_W-1:0];
		val_cl   = (div_q >= DIV_N_W'(MAX_OUT)) ? VALUE_W'(MAX_OUT) : div_q[VALUE_W-1:0];
	end

	always_comb begin
		state_d      = state_q;
		div_start    = 1'b0;
		div_n        = '0;
		div_d        = SCALE_K;
		mul_start    = 1'b0;
		mul_a        = '0;
		mul_b        = '0;
		k_load       = 1'b0;
		scale_set    = 1'b0;
		store_we     = 1'b0;
		res_load     = 1'b0;
		res_value_d  = '0;
		res_status_d = ST_OK;
		out_load     = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if (opcode_q == OP_CALIBRATE) begin
					if (ch_ok && !byp_rd) begin
						div_start = 1'b1;
						div_n     = DIV_N_W'(trim_sc);
						div_d     = SPAN_K;
						state_d   = S_DIV;
					end else begin
						res_load = 1'b1;
						state_d  = S_DONE;
					end
				end else if (!ch_ok) begin
					res_load     = 1'b1;
					res_status_d = ST_UNCAL;
					state_d      = S_DONE;
				end else if (byp_rd) begin
					res_load    = 1'b1;
					res_value_d = VALUE_W'(raw_q);
					state_d     = S_DONE;
				end else if (!cal_rd) begin
					res_load     = 1'b1;
					res_status_d = ST_UNCAL;
					state_d      = S_DONE;
				end else if (diff[DIFF_W-1]) begin
					res_load     = 1'b1;
					res_status_d = ST_NO_INPUT;
					state_d      = S_DONE;
				end else begin
					div_start = 1'b1;
					div_n     = DIV_N_W'(diff[DIFF_W-2:0]);
					div_d     = kdiv_rd;
					state_d   = S_DIV;
				end
			end
			S_DIV: begin
				if (div_done) begin
					if (opcode_q == OP_CALIBRATE) begin
						k_load    = 1'b1;
						mul_start = 1'b1;
						mul_a     = DIV_N_W'(dmag);
						mul_b     = CAL_LOW_K;
						state_d   = S_MUL;
					end else if (!scale_q) begin
						mul_start = 1'b1;
						mul_a     = div_q;
						mul_b     = gain_rom[ch_idx];
						state_d   = S_MUL;
					end else begin
						res_load    = 1'b1;
						res_value_d = val_cl;
						state_d     = S_DONE;
					end
				end
			end
			S_MUL: begin
				if (mul_done) begin
					if (opcode_q == OP_CALIBRATE) begin
						store_we = 1'b1;
						res_load = 1'b1;
						state_d  = S_DONE;
					end else begin
						div_start = 1'b1;
						div_n     = prod_sat;
						div_d     = SCALE_K;
						scale_set = 1'b1;
						state_d   = S_DIV;
					end
				end
			end
			S_DONE: begin
				if (!out_valid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			scale_q     <= 1'b0;
			out_valid_q <= 1'b0;
			cal_flags_q <= '0;
		end else begin
			state_q <= state_d;
			if (in_accept) begin
				scale_q <= 1'b0;
			end else if (scale_set) begin
				scale_q <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (store_we) begin
				cal_flags_q[ch_idx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			opcode_q    <= s_tuser[0];
			channel_q   <= s_tdata[CH_W-1:0];
			raw_q       <= s_tdata[CH_W+CODE_W-1:CH_W];
			trim_low_q  <= s_tdata[CH_W+CODE_W+TRIM_W-1:CH_W+CODE_W];
			trim_high_q <= s_tdata[CH_W+CODE_W+2*TRIM_W-1:CH_W+CODE_W+TRIM_W];
		end
		if (k_load) begin
			k_q    <= k_cl;
			dneg_q <= dneg;
		end
		if (store_we) begin
			gain_err_q[ch_idx]  <= k_q;
			ofs_store_q[ch_idx] <= ofs_cl;
		end
		if (res_load) begin
			res_value_q  <= res_value_d;
			res_status_q <= res_status_d;
		end
		if (out_load) begin
			out_value_q  <= res_value_q;
			out_status_q <= res_status_q;
		end
	end

	adc2p_div #(
		.N_W(DIV_N_W),
		.D_W(K_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_n),
		.divisor (div_d),
		.quotient(div_q),
		.done    (div_done)
	);

	adc2p_mul #(
		.A_W(DIV_N_W),
		.B_W(K_W)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.product(mul_p),
		.done   (mul_done)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = M_TDATA_W'(out_value_q);
	assign m_tuser  = out_status_q;

endmodule

### dv/tb_adc_two_point_calibration.sv
`timescale 1ns / 1ps

module tb_adc_two_point_calibration;

	import adc2p_pkg::*;

	localparam logic OP_CORRECT = 1'b1;
	localparam int   CAL_SPAN   = (DEF_CAL_CODE_HIGH - DEF_CAL_CODE_LOW) > 0 ?
		(DEF_CAL_CODE_HIGH - DEF_CAL_CODE_LOW) : 1;

	typedef struct packed {
		logic [VALUE_W-1:0]  value;
		logic [STATUS_W-1:0] status;
	} reading_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [S_TDATA_W-1:0]   s_tdata;
	logic [S_TUSER_W-1:0]   s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [M_TDATA_W-1:0]   m_tdata;
	logic [M_TUSER_W-1:0]   m_tuser;

	longint                 gain_error_q [MAX_CHANNELS];
	longint                 offset_q     [MAX_CHANNELS];
	bit                     is_calibrated[MAX_CHANNELS];
	longint                 fixed_gain   [MAX_CHANNELS];

	reading_t               expected_readings[$];
	int                     error_count   = 0;
	int                     send_idle_pct = 0;
	int                     recv_stall_pct = 0;

	adc_two_point_calibration i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint clamp_long(input longint v, input longint lo, input longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic reading_t predict_reading(input logic op, input logic [CH_W-1:0] ch,
			input logic [CODE_W-1:0] raw, input logic [TRIM_W-1:0] trim_lo,
			input logic [TRIM_W-1:0] trim_hi);
		reading_t r;
		longint   k;
		longint   ofs;
		longint   diff;
		longint   scaled;
		r.value  = '0;
		r.status = ST_OK;
		if (op == OP_CALIBRATE) begin
			if (ch < DEF_CHANNEL_COUNT && !BYPASS_INIT[ch]) begin
				k = SCALE + ((longint'(trim_hi) - longint'(trim_lo)) * SCALE) / CAL_SPAN;
				k = clamp_long(k, 1, MAX12);
				ofs = longint'(trim_lo) * SCALE - (k - SCALE) * DEF_CAL_CODE_LOW;
				gain_error_q[ch]  = k;
				offset_q[ch]      = clamp_long(ofs, OFS_MIN, OFS_MAX);
				is_calibrated[ch] = 1'b1;
			end
		end else if (ch >= DEF_CHANNEL_COUNT) begin
			r.status = ST_UNCAL;
		end else if (BYPASS_INIT[ch]) begin
			r.value = VALUE_W'(raw);
		end else if (!is_calibrated[ch]) begin
			r.status = ST_UNCAL;
		end else begin
			diff = longint'(raw) * SCALE - offset_q[ch];
			if (diff < 0) begin
				r.status = ST_NO_INPUT;
			end else begin
				k = gain_error_q[ch] != 0 ? gain_error_q[ch] : 1;
				scaled = ((diff / k) * fixed_gain[ch]) / SCALE;
				r.value = VALUE_W'(clamp_long(scaled, 0, MAX_OUT));
			end
		end
		return r;
	endfunction

	// Called right after a rising edge; leaves the request held until it is taken.
	task automatic push_request(input logic op, input logic [CH_W-1:0] ch,
			input logic [CODE_W-1:0] raw, input logic [TRIM_W-1:0] trim_lo,
			input logic [TRIM_W-1:0] trim_hi);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {trim_hi, trim_lo, raw, ch};
		s_tuser  <= op;
		do
			@(posedge clk);
		while (!s_tready);
		expected_readings.push_back(predict_reading(op, ch, raw, trim_lo, trim_hi));
	endtask

	always @(negedge clk) begin
		if (arst_n) begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		reading_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_readings.size() == 0) begin
				$display("%0t ns: unexpected reading, expected none, got value %0d status %0d",
					$time, m_tdata[VALUE_W-1:0], m_tuser);
				error_count++;
			end else begin
				want = expected_readings.pop_front();
				if (m_tdata[VALUE_W-1:0] !== want.value) begin
					$display("%0t ns: corrected_value mismatch, expected %0d, got %0d",
						$time, want.value, m_tdata[VALUE_W-1:0]);
					error_count++;
				end
				if (m_tuser !== want.status) begin
					$display("%0t ns: status mismatch, expected %0d, got %0d",
						$time, want.status, m_tuser);
					error_count++;
				end
			end
		end
	end

	function automatic logic [CODE_W-1:0] pick_code();
		case ($urandom_range(9))
			0:       return '0;
			1:       return '1;
			2:       return CODE_W'(DEF_CAL_CODE_LOW);
			default: return CODE_W'($urandom_range(4095));
		endcase
	endfunction

	function automatic logic [TRIM_W-1:0] pick_trim();
		case ($urandom_range(7))
			0:       return '0;
			1:       return '1;
			default: return TRIM_W'($urandom_range(255));
		endcase
	endfunction

	task automatic test_uncalibrated_and_bypass();
		push_request(OP_CORRECT,   4'd0,  12'd1234, 8'd0,   8'd0);
		push_request(OP_CORRECT,   4'd15, 12'd0,    8'd0,   8'd0);
		push_request(OP_CORRECT,   4'd11, 12'd4095, 8'd255, 8'd255);
		push_request(OP_CALIBRATE, 4'd12, 12'd4095, 8'd255, 8'd0);
		push_request(OP_CORRECT,   4'd12, 12'hAAA,  8'd0,   8'd0);
		push_request(OP_CALIBRATE, 4'd13, 12'd0,    8'd0,   8'd255);
		push_request(OP_CORRECT,   4'd13, 12'h555,  8'hAA,  8'h55);
	endtask

	task automatic test_calibrate_and_correct();
		push_request(OP_CALIBRATE, 4'd0,  12'd0,    8'd0,   8'd0);
		push_request(OP_CORRECT,   4'd0,  12'd0,    8'd0,   8'd0);
		push_request(OP_CORRECT,   4'd0,  12'd4095, 8'd0,   8'd0);
		push_request(OP_CORRECT,   4'd0,  12'd2064, 8'd0,   8'd0);
		push_request(OP_CALIBRATE, 4'd9,  12'd0,    8'd0,   8'd255);
		push_request(OP_CORRECT,   4'd9,  12'd4095, 8'd0,   8'd0);
		push_request(OP_CORRECT,   4'd9,  12'd3112, 8'd0,   8'd0);
		push_request(OP_CALIBRATE, 4'd14, 12'd0,    8'd255, 8'd255);
		push_request(OP_CORRECT,   4'd14, 12'd4095, 8'd0,   8'd0);
	endtask

	task automatic test_no_input();
		push_request(OP_CALIBRATE, 4'd9,  12'd0,    8'd255, 8'd0);
		push_request(OP_CORRECT,   4'd9,  12'd0,    8'd0,   8'd0);
		push_request(OP_CORRECT,   4'd9,  12'd4095, 8'd0,   8'd0);
		push_request(OP_CALIBRATE, 4'd10, 12'd0,    8'd200, 8'd10);
		push_request(OP_CORRECT,   4'd10, 12'd1,    8'd0,   8'd0);
		push_request(OP_CORRECT,   4'd10, 12'd4095, 8'd0,   8'd0);
	endtask

	task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
		logic op;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (count) begin
			op = ($urandom_range(99) < 20) ? OP_CALIBRATE : OP_CORRECT;
			push_request(op, CH_W'($urandom_range(15)), pick_code(), pick_trim(), pick_trim());
		end
	endtask

	initial begin
		for (int i = 0; i < MAX_CHANNELS; i++) begin
			gain_error_q[i]  = 0;
			offset_q[i]      = 0;
			is_calibrated[i] = 1'b0;
			fixed_gain[i]    = clamp_long(
				(longint'(VOLT_HIGH[i] - VOLT_LOW[i]) * SCALE) / CAL_SPAN, 0, MAX12);
		end
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		m_tready = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_uncalibrated_and_bypass();
		test_calibrate_and_correct();
		test_no_input();
		test_random_traffic(250, 0, 0);
		test_random_traffic(320, 74, 0);
		test_random_traffic(320, 0, 74);
		test_random_traffic(320, 15, 15);
		test_random_traffic(40, 0, 0);

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_readings.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (error_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Timeout with %0d readings outstanding.", expected_readings.size());
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

### filelist.f
hdl/adc2p_pkg.sv
hdl/adc2p_mul.sv
hdl/adc2p_div.sv
hdl/adc_two_point_calibration.sv
dv/tb_adc_two_point_calibration.sv
